### rtl/nur_replacement_policy_defines.svh
// Assertion macros for the NUR replacement policy block.
// Used by the top level only; needs nothing else.
`ifndef NUR_REPLACEMENT_POLICY_DEFINES_SVH
`define NUR_REPLACEMENT_POLICY_DEFINES_SVH

// Clocked assertion, held off while reset is high.
`define NUR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define NUR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nur_pkg.sv
// Shared constants, action codes and controller command struct for the
// NUR replacement policy. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nur_pkg;

   localparam int NUM_BLOCKS = 64;
   localparam int BLK_W      = $clog2(NUM_BLOCKS);

   localparam int PERIOD_W   = 16;
   localparam int BIU_W      = 7;
   localparam int TOTAL_W    = 32;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // action codes
   localparam logic [1:0] ACT_READ    = 2'd0;
   localparam logic [1:0] ACT_WRITE   = 2'd1;
   localparam logic [1:0] ACT_REPLACE = 2'd2;
   localparam logic [1:0] ACT_INVAL   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_REFRESH_PERIOD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCKS_IN_USE  = 8'd1;

   typedef struct packed {
      logic capture;   // load the request into the datapath
      logic execute;   // apply the request and load the response register
   } nur_cmd_type;

endpackage

`default_nettype wire

### rtl/nur_replacement_policy.sv
// Not-used-recently cache replacement policy: top level, streaming ports.
// Depends on nur_pkg, nur_ctrl, nur_datapath and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "nur_replacement_policy_defines.svh"

// Tracks valid, referenced and modified bits for 64 cache blocks. Each
// request transfer on the req_ channel yields exactly one response transfer
// on the rsp_ channel. Reads and writes mark the block referenced (writes
// also modified) and count down the access countdown; when it expires, every
// referenced bit clears and the refresh total advances. A replace request
// returns the first invalid managed block, else the first of the lowest
// class (referenced*2 + modified), and marks it valid and clean. Invalidate
// clears all valid bits and forces a refresh when a period is set.
// Sequencing: each item has a capture cycle, which loads the request, and an
// update cycle, in which the four 64-bit priority encoders pick the victim and
// all bits update; the next request is accepted in the cycle after that, even
// while the response still waits. If the response register is still held by the
// downstream side, the update cycle waits for it. Configuration writes are
// always accepted (csr_ready is tied high) and must be issued while idle.
module nur_replacement_policy
   import nur_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,

   // request channel
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [REQ_DATA_W-1:0]  req_tdata,   // [5:0] block_index, [7:6] zero
   input  wire  [1:0]             req_tuser,   // [1:0] action

   // response channel
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [5:0] victim_index, [6] refreshed,
                                               // [38:7] refresh_total, [39] zero

   // configuration write channel
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data
);

   nur_cmd_type          cmd;
   logic [BLK_W-1:0]     victim_index;
   logic                 refreshed;
   logic [TOTAL_W-1:0]   refresh_total;

   assign csr_ready = 1'b1;

   // sequencing: capture cycle, then execute cycle
   nur_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // block state, victim search and response payload
   nur_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_action        (req_tuser),
      .req_block_index   (req_tdata[BLK_W-1:0]),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_victim_index  (victim_index),
      .rsp_refreshed     (refreshed),
      .rsp_refresh_total (refresh_total)
   );

   assign rsp_tdata = {1'b0, refresh_total, refreshed, victim_index};

   // an accepted request blocks further requests for the next cycle
   `NUR_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "request accepted while previous one in flight")
   // an executed item always presents a response next cycle
   `NUR_ASSERT(a_exec_gives_rsp, clock, reset, cmd.execute |=> rsp_tvalid, "executed item without response")
   // capture and execute never coincide
   `NUR_ASSERT_ALWAYS(a_cmd_exclusive, clock, $onehot0({cmd.capture, cmd.execute}), "capture and execute issued together")

endmodule

`default_nettype wire

### rtl/nur_ctrl.sv
// Controller for the NUR replacement policy: request/response sequencing.
// Depends on nur_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nur_ctrl
   import nur_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output nur_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.execute)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/nur_datapath.sv
// Datapath for the NUR replacement policy: per-block bits, countdown,
// victim search and response register. Depends on nur_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nur_datapath
   import nur_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  nur_cmd_type            cmd,
   input  wire  [1:0]             req_action,
   input  wire  [BLK_W-1:0]       req_block_index,
   input  wire                    csr_write,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data,
   output logic [BLK_W-1:0]       rsp_victim_index,
   output logic                   rsp_refreshed,
   output logic [TOTAL_W-1:0]     rsp_refresh_total
);

   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;
   logic [NUM_BLOCKS-1:0] ref_ff, ref_in;
   logic [NUM_BLOCKS-1:0] mod_ff, mod_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [PERIOD_W-1:0]   cd_ff, cd_in;
   logic [BIU_W-1:0]      nblk_ff, nblk_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;

   logic [1:0]            act_ff;
   logic [BLK_W-1:0]      blk_ff;

   logic [BLK_W-1:0]      victim_ff, victim_in;
   logic                  refreshed_ff, refreshed_in;
   logic [TOTAL_W-1:0]    rtotal_ff;

   logic [NUM_BLOCKS-1:0] managed;
   logic [NUM_BLOCKS-1:0] m_inv, m_c0, m_c1, m_c2;
   logic [BLK_W-1:0]      i_inv, i_c0, i_c1, i_c2;
   logic                  f_inv, f_c0, f_c1, f_c2;
   logic [BLK_W-1:0]      victim;
   logic                  blk_managed;
   logic [BIU_W-1:0]      biu_value;

   // managed range mask
   always_comb begin
      for (int i = 0; i < NUM_BLOCKS; i++)
         managed[i] = (i < int'(nblk_ff));
   end

   assign m_inv = ~valid_ff & managed;
   assign m_c0  = ~ref_ff & ~mod_ff & managed;
   assign m_c1  = ~ref_ff &  mod_ff & managed;
   assign m_c2  =  ref_ff & ~mod_ff & managed;

   // four lowest-index priority encoders
   always_comb begin
      i_inv = '0; i_c0 = '0; i_c1 = '0; i_c2 = '0;
      f_inv = 1'b0; f_c0 = 1'b0; f_c1 = 1'b0; f_c2 = 1'b0;
      for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
         if (m_inv[i]) begin i_inv = BLK_W'(i); f_inv = 1'b1; end
         if (m_c0[i])  begin i_c0  = BLK_W'(i); f_c0  = 1'b1; end
         if (m_c1[i])  begin i_c1  = BLK_W'(i); f_c1  = 1'b1; end
         if (m_c2[i])  begin i_c2  = BLK_W'(i); f_c2  = 1'b1; end
      end
   end

   // class 3 everywhere: block 0 wins
   always_comb begin
      if (f_inv)     victim = i_inv;
      else if (f_c0) victim = i_c0;
      else if (f_c1) victim = i_c1;
      else if (f_c2) victim = i_c2;
      else           victim = '0;
   end

   assign blk_managed = (int'(blk_ff) < int'(nblk_ff));

   // clamp blocks_in_use to 1..NUM_BLOCKS
   always_comb begin
      biu_value = csr_data[BIU_W-1:0];
      if (biu_value == '0)
         biu_value = BIU_W'(1);
      else if (int'(biu_value) > NUM_BLOCKS)
         biu_value = BIU_W'(NUM_BLOCKS);
   end

   always_comb begin
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      mod_in       = mod_ff;
      period_in    = period_ff;
      cd_in        = cd_ff;
      nblk_in      = nblk_ff;
      total_in     = total_ff;
      victim_in    = '0;
      refreshed_in = 1'b0;

      if (csr_write) begin
         case (csr_index)
            REG_REFRESH_PERIOD: begin
               period_in = csr_data;
               cd_in     = csr_data;
            end
            REG_BLOCKS_IN_USE: nblk_in = biu_value;
            default: ;
         endcase
      end

      if (cmd.execute) begin
         case (act_ff)
            ACT_READ, ACT_WRITE: begin
               if (period_ff != '0) begin
                  if (cd_ff <= PERIOD_W'(1)) begin
                     ref_in       = '0;
                     cd_in        = period_ff;
                     total_in     = total_ff + TOTAL_W'(1);
                     refreshed_in = 1'b1;
                  end else begin
                     cd_in = cd_ff - PERIOD_W'(1);
                  end
               end
               // set after any refresh
               if (blk_managed) begin
                  ref_in[blk_ff] = 1'b1;
                  if (act_ff == ACT_WRITE)
                     mod_in[blk_ff] = 1'b1;
               end
            end
            ACT_REPLACE: begin
               victim_in        = victim;
               valid_in[victim] = 1'b1;
               mod_in[victim]   = 1'b0;
            end
            ACT_INVAL: begin
               valid_in = '0;
               if (period_ff != '0) begin
                  ref_in       = '0;
                  cd_in        = period_ff;
                  total_in     = total_ff + TOTAL_W'(1);
                  refreshed_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         ref_ff    <= '0;
         mod_ff    <= '0;
         period_ff <= '0;
         cd_ff     <= '0;
         nblk_ff   <= BIU_W'(NUM_BLOCKS);
         total_ff  <= '0;
      end else begin
         valid_ff  <= valid_in;
         ref_ff    <= ref_in;
         mod_ff    <= mod_in;
         period_ff <= period_in;
         cd_ff     <= cd_in;
         nblk_ff   <= nblk_in;
         total_ff  <= total_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         blk_ff <= req_block_index;
      end
      if (cmd.execute) begin
         victim_ff    <= victim_in;
         refreshed_ff <= refreshed_in;
         rtotal_ff    <= total_in;
      end
   end

   assign rsp_victim_index  = victim_ff;
   assign rsp_refreshed     = refreshed_ff;
   assign rsp_refresh_total = rtotal_ff;

endmodule

`default_nettype wire
